@@ hw/rtl/sipc_pkg.sv @@
// ----------------------------------------------------------------------------
// sipc_pkg
// shared types, codes and character helpers for the percent codec
// ----------------------------------------------------------------------------
package sipc_pkg;

    // mode register codes
    localparam logic [1:0] MODE_ENC_USER  = 2'd0;
    localparam logic [1:0] MODE_ENC_PARAM = 2'd1;
    localparam logic [1:0] MODE_DECODE    = 2'd2;

    localparam logic [7:0] CHAR_PCT  = 8'h25;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [3:0] NIB_MASK  = 4'h0f;

    // decoder escape phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HI   = 2'd1,
        PH_LO   = 2'd2
    } phase_t;

    // what the front does with one accepted byte
    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_PASS = 2'd1,
        ACT_ESC  = 2'd2,
        ACT_FAIL = 2'd3
    } action_t;

    // one queued job: a single result or a three-byte escape
    typedef struct packed {
        logic       esc;
        logic [7:0] data;
        logic       last;
        logic       err;
    } job_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_mark(input logic [7:0] c);
        return c == "-" || c == "_" || c == "." || c == "!" || c == "~" ||
               c == "*" || c == 8'h27 || c == "(" || c == ")";
    endfunction

    function automatic logic passes(input logic [7:0] c, input logic [1:0] m);
        logic extra;
        if (m == MODE_ENC_USER) begin
            extra = c == "&" || c == "=" || c == "+" || c == "$" || c == "," ||
                    c == ";" || c == "?" || c == "/";
        end else begin
            extra = c == "[" || c == "]" || c == "/" || c == ":" || c == "&" ||
                    c == "+" || c == "$";
        end
        return is_alnum(c) || is_mark(c) || extra;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= "0" && c <= "9") begin
            v = {1'b0, c[3:0]};
        end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [3:0] n;
        n = nib & NIB_MASK;
        return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
    endfunction

endpackage

@@ hw/rtl/sipc_front.sv @@
// ----------------------------------------------------------------------------
// sipc_front
// accepts input bytes, tracks escape state and queues result jobs
// ----------------------------------------------------------------------------
module sipc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_mode,
    input  logic             fire,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             push,
    output sipc_pkg::job_t   push_job
);
    import sipc_pkg::*;

    logic [1:0] mode_reg,        mode_next;
    phase_t     phase_reg,       phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       discarding_reg,  discarding_next;

    action_t    act;
    logic [7:0] pass_byte;
    logic [4:0] hv;
    logic [7:0] dec_val;

    assign hv      = hex_value(in_byte);
    assign dec_val = {high_nibble_reg, hv[3:0]};

    // classification of the incoming byte
    always_comb begin
        act       = ACT_NONE;
        pass_byte = in_byte;
        if (!discarding_reg) begin
            case (mode_reg)
                MODE_ENC_USER, MODE_ENC_PARAM: begin
                    if (in_byte < PRINT_LO || in_byte > PRINT_HI) act = ACT_FAIL;
                    else if (passes(in_byte, mode_reg))          act = ACT_PASS;
                    else                                         act = ACT_ESC;
                end
                MODE_DECODE: begin
                    case (phase_reg)
                        PH_IDLE: begin
                            if (in_byte != CHAR_PCT) act = ACT_PASS;
                            else if (in_last)        act = ACT_FAIL;
                            else                     act = ACT_NONE;
                        end
                        PH_HI: begin
                            if (hv[4] || in_last) act = ACT_FAIL;
                            else                  act = ACT_NONE;
                        end
                        default: begin
                            if (hv[4] || dec_val < PRINT_LO || dec_val > PRINT_HI) begin
                                act = ACT_FAIL;
                            end else begin
                                act       = ACT_PASS;
                                pass_byte = dec_val;
                            end
                        end
                    endcase
                end
                default: act = ACT_FAIL;
            endcase
        end
    end

    // next state
    always_comb begin
        mode_next        = mode_reg;
        phase_next       = phase_reg;
        high_nibble_next = high_nibble_reg;
        discarding_next  = discarding_reg;
        if (cfg_we) begin
            mode_next        = cfg_mode;
            phase_next       = PH_IDLE;
            high_nibble_next = 4'h0;
            discarding_next  = 1'b0;
        end else if (fire) begin
            if (discarding_reg) begin
                if (in_last) discarding_next = 1'b0;
            end else if (act == ACT_FAIL) begin
                phase_next       = PH_IDLE;
                high_nibble_next = 4'h0;
                discarding_next  = !in_last;
            end else if (mode_reg == MODE_DECODE) begin
                case (phase_reg)
                    PH_IDLE: begin
                        if (act == ACT_NONE) phase_next = PH_HI;
                    end
                    PH_HI: begin
                        high_nibble_next = hv[3:0];
                        phase_next       = PH_LO;
                    end
                    default: begin
                        high_nibble_next = 4'h0;
                        phase_next       = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // job output
    always_comb begin
        push          = fire && !discarding_reg && (act != ACT_NONE);
        push_job.esc  = (act == ACT_ESC);
        push_job.err  = (act == ACT_FAIL);
        push_job.data = (act == ACT_FAIL) ? 8'h00 : pass_byte;
        push_job.last = (act == ACT_FAIL) ? 1'b1 : in_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_ENC_USER;
            phase_reg       <= PH_IDLE;
            high_nibble_reg <= 4'h0;
            discarding_reg  <= 1'b0;
        end else begin
            mode_reg        <= mode_next;
            phase_reg       <= phase_next;
            high_nibble_reg <= high_nibble_next;
            discarding_reg  <= discarding_next;
        end
    end

endmodule

@@ hw/rtl/sipc_fifo.sv @@
// ----------------------------------------------------------------------------
// sipc_fifo
// small job queue between front and back
// ----------------------------------------------------------------------------
module sipc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sipc_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output sipc_pkg::job_t pop_job
);
    import sipc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/sipc_back.sv @@
// ----------------------------------------------------------------------------
// sipc_back
// expands queued jobs into result bytes, one per cycle while out_ready is high
// ----------------------------------------------------------------------------
module sipc_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    input  sipc_pkg::job_t job_in,
    output logic           job_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_byte,
    output logic           out_last,
    output logic           out_error
);
    import sipc_pkg::*;

    logic       cur_valid_reg, cur_valid_next;
    job_t       cur_job_reg,   cur_job_next;
    logic [1:0] step_reg,      step_next;
    logic       final_step, load;

    assign final_step = !cur_job_reg.esc || (step_reg == 2'd2);
    assign load       = !cur_valid_reg || (out_ready && final_step);
    assign job_pop    = load && job_valid;

    assign out_valid  = cur_valid_reg;
    assign out_error  = cur_job_reg.err;
    assign out_last   = cur_job_reg.last && final_step;

    always_comb begin
        if (!cur_job_reg.esc) begin
            out_byte = cur_job_reg.data;
        end else begin
            case (step_reg)
                2'd0:    out_byte = CHAR_PCT;
                2'd1:    out_byte = hex_char(cur_job_reg.data[7:4]);
                default: out_byte = hex_char(cur_job_reg.data[3:0]);
            endcase
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_job_next   = cur_job_reg;
        step_next      = step_reg;
        if (load) begin
            cur_valid_next = job_valid;
            cur_job_next   = job_in;
            step_next      = 2'd0;
        end else if (out_ready) begin
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_job_reg <= cur_job_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
        end
    end

endmodule

@@ hw/rtl/sip_uri_percent_codec_top.sv @@
// ----------------------------------------------------------------------------
// sip_uri_percent_codec_top
// streaming uri percent encoder / decoder for sip user and parameter parts
// ----------------------------------------------------------------------------
// the block takes one input byte per cycle while the job queue has room and
// gives one result byte per cycle while m_tready is high. a byte that passes
// through, a decoded escape and an error each make one result; an encoded byte
// makes three ('%' and two lowercase hex digits), which the back end sends
// while the front keeps taking input until the job queue (DEPTH jobs) is full,
// so a long run of escaped bytes is limited by the single output port. in
// decode mode the '%' and first hex digit produce nothing, so three input
// bytes give one result. the first result of a byte is offered once its job
// has passed the queue and been loaded into the output register. the user must
// write the mode register through cfg_valid/cfg_ready only while the block is
// idle; the block does not enforce this. a write also resets the escape and
// discard state. after an error the rest of the string up to and including the
// byte marked last is dropped. there is no clearing pass.
module sip_uri_percent_codec_top #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: mode register
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    input  logic       s_tlast,     // in_last
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic       m_tlast,     // out_last
    output logic [0:0] m_tuser      // [0] out_error
);
    import sipc_pkg::*;

    logic fifo_full, fifo_not_empty, fifo_pop, push, fire, cfg_we;
    job_t push_job, pop_job;

    // config is always taken, so the user must write it only while idle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // input stalls only when the job queue has no room
    assign s_tready  = !fifo_full;
    assign fire      = s_tvalid && s_tready;

    // front: classify and track escape state
    sipc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_mode (cfg_data),
        .fire     (fire),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .push     (push),
        .push_job (push_job)
    );

    // queue decouples the two sides
    sipc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .pop_job   (pop_job)
    );

    // back: one result transaction per cycle while m_tready is high
    sipc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (fifo_not_empty),
        .job_in    (pop_job),
        .job_pop   (fifo_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_error (m_tuser[0])
    );

endmodule

@@ hw/rtl/sipc_checker.sv @@
// ----------------------------------------------------------------------------
// sipc_checker
// port-level checks on the percent codec, bound to the top level
// ----------------------------------------------------------------------------
module sipc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [0:0] m_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // an error result is zero and closes the string
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
        else $error("error result not last or not zero");

    // a mode write is always taken
    a_cfg_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("mode write not taken");

    // a stalled input byte holds
    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("stalled input changed");

    // a stalled result holds
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
        $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind sip_uri_percent_codec_top sipc_checker u_sipc_checker (.*);
